// File: hw/rtl/bcc_pkg.sv
// Package: shared types, widths and event codes of the button click classifier.
package bcc_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_DOUBLE_CLICK = 1'd1;

  localparam logic [CfgW-1:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [CfgW-1:0] DOUBLE_CLICK_RST = 16'd300;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_LONG   = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_SHORT  = 2'd3
  } click_event_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             key_down;
  } sample_t;

  typedef struct packed {
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] double_click_ms;
  } cfg_t;

endpackage

// File: hw/rtl/bcc_if.sv
// Interfaces: sample, event and configuration channels.
interface bcc_in_if;
  logic                        valid;
  logic                        ready;
  logic [bcc_pkg::TimeW-1:0]   now_ms;
  logic                        key_down;
  modport source (output valid, output now_ms, output key_down, input ready);
  modport sink   (input valid, input now_ms, input key_down, output ready);
endinterface

interface bcc_out_if;
  logic                        valid;
  logic                        ready;
  bcc_pkg::click_event_t       click_event;
  modport source (output valid, output click_event, input ready);
  modport sink   (input valid, input click_event, output ready);
endinterface

interface bcc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bcc_pkg::CfgIdxW-1:0] index;
  logic [bcc_pkg::CfgW-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/bcc_cfg_regs.sv
// Configuration registers: long press threshold and double click window.
module bcc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [bcc_pkg::CfgIdxW-1:0] wr_index,
  input  logic [bcc_pkg::CfgW-1:0]    wr_data,
  output bcc_pkg::cfg_t               cfg
);
  import bcc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_LONG_PRESS:   cfg_nxt.long_press_ms   = wr_data;
        CFG_DOUBLE_CLICK: cfg_nxt.double_click_ms = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms   <= LONG_PRESS_RST;
      cfg_r.double_click_ms <= DOUBLE_CLICK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/bcc_classifier.sv
// Click classifier: button state registers and the per-sample event decision.
module bcc_classifier (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  bcc_pkg::sample_t      sample,
  input  bcc_pkg::cfg_t         cfg,
  output bcc_pkg::click_event_t ev
);
  import bcc_pkg::*;

  logic             was_down_r,      was_down_nxt;
  logic             short_pending_r, short_pending_nxt;
  logic [TimeW-1:0] press_time_r,    press_time_nxt;
  logic [TimeW-1:0] release_time_r,  release_time_nxt;

  logic [TimeW-1:0] held;
  logic [TimeW-1:0] since_rel;
  logic             is_long;
  logic             in_window;
  logic             rise;
  logic             fall;

  // wrap-around differences
  assign held      = sample.now_ms - press_time_r;
  assign since_rel = sample.now_ms - release_time_r;
  assign is_long   = held >= {{(TimeW-CfgW){1'b0}}, cfg.long_press_ms};
  assign in_window = since_rel <= {{(TimeW-CfgW){1'b0}}, cfg.double_click_ms};
  assign rise      = sample.key_down && !was_down_r;
  assign fall      = !sample.key_down && was_down_r;

  always_comb begin
    was_down_nxt      = was_down_r;
    short_pending_nxt = short_pending_r;
    press_time_nxt    = press_time_r;
    release_time_nxt  = release_time_r;
    ev                = EV_NONE;
    priority if (fall) begin
      was_down_nxt = 1'b0;
      priority if (is_long) begin
        short_pending_nxt = 1'b0;
        ev                = EV_LONG;
      end else if (in_window) begin
        short_pending_nxt = 1'b0;
        release_time_nxt  = '0;
        ev                = EV_DOUBLE;
      end else begin
        // arm; zero elapsed time can never exceed the window
        short_pending_nxt = 1'b1;
        release_time_nxt  = sample.now_ms;
      end
    end else if (rise) begin
      was_down_nxt   = 1'b1;
      press_time_nxt = sample.now_ms;
    end else if (short_pending_r && !sample.key_down && !in_window) begin
      short_pending_nxt = 1'b0;
      ev                = EV_SHORT;
    end else begin
      ev = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_down_r      <= 1'b0;
      short_pending_r <= 1'b0;
      press_time_r    <= '0;
      release_time_r  <= '0;
    end else if (fire) begin
      was_down_r      <= was_down_nxt;
      short_pending_r <= short_pending_nxt;
      press_time_r    <= press_time_nxt;
      release_time_r  <= release_time_nxt;
    end
  end

`ifndef SYNTH
  a_down_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    fire && sample.key_down |-> ev == EV_NONE)
    else $error("event reported while key is down");

  a_short_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ev == EV_SHORT |=> !short_pending_r)
    else $error("pending short not cleared after report");

  a_short_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ev == EV_SHORT |-> short_pending_r)
    else $error("short reported without a pending short");
`endif

endmodule

// File: hw/rtl/button_click_classifier.sv
// Top level: button click classifier with sample register and event register.
// Each accepted sample is held in the sample register, then classified into the event register.
// Throughput: one sample per cycle while the event channel takes events; the state update is a subtract-compare.
// A full sample register is held only while the event register is full and not taken.
// Reset (synchronous, rst_n low): channels empty, button state zero,
// thresholds back to 1000 ms long press and 300 ms double click window.
module button_click_classifier (
  input  logic             clk,
  input  logic             rst_n,
  bcc_in_if.sink           in_ch,
  bcc_out_if.source        out_ch,
  bcc_cfg_if.sink          cfg_ch
);
  import bcc_pkg::*;

  // sample (input) register
  logic         in_v_r, in_v_nxt;
  sample_t      in_smp_r;
  // event (output) register
  logic         out_v_r, out_v_nxt;
  click_event_t out_ev_r;

  logic         advance;   // event register can take a new value
  logic         fire;      // registered sample is classified this cycle
  logic         in_take;   // input transaction
  sample_t      in_smp;
  cfg_t         cfg;
  click_event_t ev;

  assign advance = !out_v_r || out_ch.ready;
  assign fire    = in_v_r && advance;
  assign in_take = in_ch.valid && in_ch.ready;

  // accept whenever the sample register is empty or moves on this cycle
  assign in_ch.ready = !in_v_r || advance;

  assign in_smp.now_ms   = in_ch.now_ms;
  assign in_smp.key_down = in_ch.key_down;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
  end

  assign out_v_nxt = advance ? in_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_smp_r <= in_smp;
    end
    if (fire) begin
      out_ev_r <= ev;
    end
  end

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  bcc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // state update and classification happen in the cycle the event is registered
  bcc_classifier u_cls (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .sample (in_smp_r),
    .cfg    (cfg),
    .ev     (ev)
  );

  assign out_ch.valid       = out_v_r;
  assign out_ch.click_event = out_ev_r;

`ifndef SYNTH
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |-> !in_ch.ready)
    else $error("input accepted while sample register is stalled");

  a_fire_gives_event: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_v_r)
    else $error("classified sample produced no event");

  a_no_phantom_event: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !in_v_r |=> !out_v_r)
    else $error("event valid without a sample");
`endif

endmodule

// File: bench/bcc_checker.sv
// Checker: predicts click events from accepted samples and compares them with the block's output.
module bcc_checker
  import bcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [TimeW-1:0]   in_now_ms,
  input  logic               in_key_down,
  input  logic               out_valid,
  input  logic               out_ready,
  input  click_event_t       out_click_event,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CfgW-1:0]  long_ms;
  logic [CfgW-1:0]  dbl_ms;
  logic             key_was_down;
  logic             short_armed;
  logic [TimeW-1:0] press_at;
  logic [TimeW-1:0] release_at;
  click_event_t     expected_events[$];

  // Button state update for one sample; returns the event it causes.
  function automatic click_event_t classify_sample(logic [TimeW-1:0] now, logic down);
    logic [TimeW-1:0] held;
    logic [TimeW-1:0] since_release;
    if (down && !key_was_down) begin
      press_at     = now;
      key_was_down = 1'b1;
    end else if (!down && key_was_down) begin
      held          = now - press_at;
      since_release = now - release_at;
      key_was_down  = 1'b0;
      if (held >= {16'b0, long_ms}) begin
        short_armed = 1'b0;
        return EV_LONG;
      end
      if (since_release <= {16'b0, dbl_ms}) begin
        short_armed = 1'b0;
        release_at  = '0;
        return EV_DOUBLE;
      end
      short_armed = 1'b1;
      release_at  = now;
    end
    since_release = now - release_at;
    if (short_armed && !down && since_release > {16'b0, dbl_ms}) begin
      short_armed = 1'b0;
      return EV_SHORT;
    end
    return EV_NONE;
  endfunction

  function automatic void flag_event(string what, click_event_t got);
    if (fail_count < 10) $display("%0t: %s, got %s", $time, what, got.name());
    fail_count++;
  endfunction

  always @(posedge clk) begin
    click_event_t want;
    if (!rst_n) begin
      long_ms      = LONG_PRESS_RST;
      dbl_ms       = DOUBLE_CLICK_RST;
      key_was_down = 1'b0;
      short_armed  = 1'b0;
      press_at     = '0;
      release_at   = '0;
      fail_count   = 0;
      expected_events.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          flag_event("event with no sample outstanding", out_click_event);
        end else begin
          want = expected_events.pop_front();
          if (want != out_click_event)
            flag_event($sformatf("event mismatch: expected %s", want.name()), out_click_event);
        end
      end
      if (in_valid && in_ready)
        expected_events.push_back(classify_sample(in_now_ms, in_key_down));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LONG_PRESS:   long_ms = cfg_data;
          CFG_DOUBLE_CLICK: dbl_ms  = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_events.size();
  end

endmodule

// File: bench/tb_button_click_classifier.sv
// Testbench top: drives samples and threshold writes into the click classifier and reports the verdict.
module tb_button_click_classifier;
  import bcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Idle cycles without any transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Tail wait after the last event.
  localparam int TAIL_CYCLES    = 4;
  localparam int PHASE_ITEMS    = 90;

  logic clk;
  logic rst_n;

  bcc_in_if  in_if ();
  bcc_out_if out_if ();
  bcc_cfg_if cfg_if ();

  int fail_count;
  int pending;

  // Stimulus-side copies of the thresholds, used only to aim timestamps at the boundaries.
  logic [CfgW-1:0]  long_cfg;
  logic [CfgW-1:0]  dbl_cfg;
  logic [TimeW-1:0] t_ms;        // running timestamp of the click sequences
  logic             steady;      // phase without idle cycles on either side
  int               items_sent;
  int               idle_cycles;

  button_click_classifier dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  bcc_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_if.valid),
    .in_ready        (in_if.ready),
    .in_now_ms       (in_if.now_ms),
    .in_key_down     (in_if.key_down),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_click_event (out_if.click_event),
    .cfg_valid       (cfg_if.valid),
    .cfg_ready       (cfg_if.ready),
    .cfg_index       (cfg_if.index),
    .cfg_data        (cfg_if.data),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Event sink: per event, a randomly drawn stall with ready low unless the phase runs steady.
  // Ready stays high straight into the next event when no stall is drawn.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      @(negedge clk);
    end
  end

  // One sample transaction; entered and left at a falling edge.
  // Valid is only lowered when a gap is drawn, never dropped and raised in one step.
  task automatic send_sample(logic [TimeW-1:0] now, logic down);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.now_ms   <= now;
    in_if.key_down <= down;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
  endtask

  // Thresholds change only with the block drained: every sample yields an event,
  // so an empty expectation queue means nothing is left in flight.
  task automatic set_thresholds(logic [CfgW-1:0] long_v, logic [CfgW-1:0] dbl_v);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    write_reg(CFG_LONG_PRESS, long_v);
    write_reg(CFG_DOUBLE_CLICK, dbl_v);
    cfg_if.valid <= 1'b0;
    long_cfg = long_v;
    dbl_cfg  = dbl_v;
  endtask

  // Time offset around a threshold: just below, on it, just above, spread out, or near zero.
  function automatic logic [TimeW-1:0] near(logic [TimeW-1:0] v);
    case ($urandom_range(0, 5))
      0:       return (v == 0) ? '0 : v - 1;
      1:       return v;
      2:       return v + 1;
      3:       return $urandom_range(0, v);
      4:       return $urandom_range(v, 2 * v + 2);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  // A well-formed click: a few key-up samples, press, held samples, release.
  // Half the clicks aim the release-to-release span at the double window,
  // the rest aim the hold at the long threshold.
  task automatic send_click();
    logic [TimeW-1:0] rel;
    logic [TimeW-1:0] target;
    logic [TimeW-1:0] hold;
    logic [TimeW-1:0] pressed;
    rel = t_ms;
    repeat ($urandom_range(0, 2)) send_sample(rel + near({16'b0, dbl_cfg}), 1'b0);
    if ($urandom_range(0, 1) == 1) begin
      target = near({16'b0, dbl_cfg});
      hold   = $urandom_range(0, target);
    end else begin
      hold   = near({16'b0, long_cfg});
      target = hold + $urandom_range(0, dbl_cfg + 2);
    end
    pressed = rel + target - hold;
    send_sample(pressed, 1'b1);
    repeat ($urandom_range(0, 2)) send_sample(pressed + $urandom_range(0, hold), 1'b1);
    t_ms = pressed + hold;
    send_sample(t_ms, 1'b0);
  endtask

  initial begin
    int start;
    logic [CfgW-1:0] long_v;
    logic [CfgW-1:0] dbl_v;

    // Known values on every input before and during reset.
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.now_ms   = '0;
    in_if.key_down = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CFG_LONG_PRESS;
    cfg_if.data    = '0;
    steady         = 1'b0;
    items_sent     = 0;
    long_cfg       = LONG_PRESS_RST;
    dbl_cfg        = DOUBLE_CLICK_RST;
    t_ms           = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset thresholds (1000 ms long, 300 ms window).
    send_sample(32'd0, 1'b0);
    send_sample(32'd100, 1'b1);          // press edge
    send_sample(32'd200, 1'b0);          // release near zero release time -> double
    send_sample(32'd250, 1'b1);
    send_sample(32'd1250, 1'b0);         // hold exactly at threshold -> long
    send_sample(32'd2000, 1'b1);
    send_sample(32'd2999, 1'b0);         // hold one short of threshold, arms short
    send_sample(32'd3299, 1'b0);         // window edge, still pending
    send_sample(32'd3300, 1'b0);         // one past the window -> short
    send_sample(32'd3400, 1'b1);
    send_sample(32'd3500, 1'b0);         // arms short
    send_sample(32'd3600, 1'b1);
    send_sample(32'd3800, 1'b0);         // exactly on the window -> double
    send_sample(32'd4000, 1'b1);
    send_sample(32'd4100, 1'b0);         // arms short
    send_sample(32'd4500, 1'b1);         // key down past window: no short while held
    send_sample(32'd4600, 1'b1);
    send_sample(32'd4700, 1'b0);         // re-arms instead of a second short
    send_sample(32'd5001, 1'b0);         // the single short
    send_sample(32'd6000, 1'b0);
    send_sample(32'hFFFF_FF00, 1'b1);    // press just before timestamp wrap
    send_sample(32'h0000_0100, 1'b0);    // held across wrap
    send_sample(32'h0000_0300, 1'b0);    // short after wrap
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0000_0000, 1'b0);

    // Random phases across threshold settings, extremes included.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       begin long_v = 16'd0;     dbl_v = 16'd0;     end
        1:       begin long_v = 16'hFFFF;  dbl_v = 16'hFFFF;  end
        2:       begin long_v = 16'd0;     dbl_v = 16'hFFFF;  end
        3:       begin long_v = 16'hFFFF;  dbl_v = 16'd0;     end
        4:       begin long_v = 16'd40;    dbl_v = 16'd15;    end
        5:       begin long_v = LONG_PRESS_RST; dbl_v = DOUBLE_CLICK_RST; end
        default: begin
          long_v = 16'($urandom_range(0, 65535));
          dbl_v  = 16'($urandom_range(0, 65535));
        end
      endcase
      set_thresholds(long_v, dbl_v);
      steady = ($urandom_range(0, 3) == 0);
      // Run the widest window across the 32-bit wrap.
      if (phase == 1) t_ms = 32'hFFFF_0000;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        // Mostly clean clicks; some fully random samples break the sequences.
        if ($urandom_range(0, 9) == 0) send_sample($urandom, 1'($urandom_range(0, 1)));
        else send_click();
      end
    end

    // Drain, then give the block its latency in case of stray events.
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
